// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the bracket checker. Empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Generic clocked property, held off during reset.
`define BBC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bbc: property check failed");
// Same-cycle implication.
`define BBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bbc: implication check failed");
`else
`define BBC_ASSERT(lbl, clk, rstn, prop)
`define BBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/bbc_pkg.sv -----
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    // bracket characters
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // bracket kinds as stored on the stack
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    // verdict codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_UNCLOSED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // one classified byte, front to back
    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       last;
    } item_t;

endpackage

// ----- rtl/core/bbc_front.sv -----
module bbc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        char_code,
    input  logic              is_last,
    input  logic              in_valid,
    output logic              in_ready,
    output bbc_pkg::item_t    item,
    output logic              item_valid,
    input  logic              item_ready
);

    bbc_pkg::item_t item_next;
    bbc_pkg::item_t item_reg;
    logic           valid_reg;
    logic           valid_next;

    // byte decode
    always_comb
    begin
        item_next.last = is_last;
        item_next.op   = bbc_pkg::OP_NONE;
        item_next.kind = bbc_pkg::KIND_ROUND;
        unique case (char_code)
            bbc_pkg::CH_OPEN_ROUND:
            begin
                item_next.op   = bbc_pkg::OP_PUSH;
                item_next.kind = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CH_OPEN_SQUARE:
            begin
                item_next.op   = bbc_pkg::OP_PUSH;
                item_next.kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CH_OPEN_CURLY:
            begin
                item_next.op   = bbc_pkg::OP_PUSH;
                item_next.kind = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CH_OPEN_ANGLE:
            begin
                item_next.op   = bbc_pkg::OP_PUSH;
                item_next.kind = bbc_pkg::KIND_ANGLE;
            end
            bbc_pkg::CH_CLOSE_ROUND:
            begin
                item_next.op   = bbc_pkg::OP_POP;
                item_next.kind = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CH_CLOSE_SQUARE:
            begin
                item_next.op   = bbc_pkg::OP_POP;
                item_next.kind = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CH_CLOSE_CURLY:
            begin
                item_next.op   = bbc_pkg::OP_POP;
                item_next.kind = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CH_CLOSE_ANGLE:
            begin
                item_next.op   = bbc_pkg::OP_POP;
                item_next.kind = bbc_pkg::KIND_ANGLE;
            end
            default:
            begin
                item_next.op   = bbc_pkg::OP_NONE;
                item_next.kind = bbc_pkg::KIND_ROUND;
            end
        endcase
    end

    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ----- rtl/core/bbc_queue.sv -----
module bbc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  bbc_pkg::item_t    wr_item,
    input  logic              wr_valid,
    output logic              wr_ready,
    output bbc_pkg::item_t    rd_item,
    output logic              rd_valid,
    input  logic              rd_ready
);

    localparam int PW = (bbc_pkg::QUEUE_DEPTH > 1) ? $clog2(bbc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    bbc_pkg::item_t  entry_reg [bbc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = count_reg != CW'(bbc_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ----- rtl/core/bbc_exec.sv -----
`include "assert_macros.svh"

module bbc_exec
#(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bbc_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              legal,
    output logic [1:0]        status,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [1:0]    stack_mem_reg [STACK_DEPTH];
    logic [1:0]    top_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    fail_reg;
    logic [1:0]    fail_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          legal_reg;
    logic [1:0]    status_reg;
    logic [1:0]    verdict;
    logic          take;
    logic          do_push;
    logic          do_pop;
    logic          full;
    logic [CW-1:0] count_m2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // a verdict may not overwrite one still waiting
    assign item_ready = !(item.last && out_valid_reg && !out_ready);
    assign take       = item_valid && item_ready;
    assign full       = count_reg == CW'(STACK_DEPTH);
    assign count_m2   = count_reg - CW'(2);
    assign wr_addr    = count_reg[AW-1:0];
    assign rd_addr    = count_m2[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        fail_next  = fail_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        verdict    = bbc_pkg::ST_OK;
        if (take)
        begin
            if (fail_reg == bbc_pkg::ST_OK)
            begin
                if (item.op == bbc_pkg::OP_PUSH)
                begin
                    if (full)
                        fail_next = bbc_pkg::ST_OVERFLOW;
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (item.op == bbc_pkg::OP_POP)
                begin
                    if (count_reg == '0 || top_reg != item.kind)
                        fail_next = bbc_pkg::ST_MISMATCH;
                    else
                    begin
                        do_pop     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            if (fail_next != bbc_pkg::ST_OK)
                verdict = fail_next;
            else if (count_next != '0)
                verdict = bbc_pkg::ST_UNCLOSED;
            if (item.last)
            begin
                count_next = '0;
                fail_next  = bbc_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && item.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fail_reg      <= bbc_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stack RAM; top entry mirrored in top_reg so a pop sees it at once
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem_reg[wr_addr] <= item.kind;
            top_reg                <= item.kind;
        end
        else if (do_pop)
            top_reg <= stack_mem_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last)
        begin
            legal_reg  <= verdict == bbc_pkg::ST_OK;
            status_reg <= verdict;
        end
    end

    assign legal     = legal_reg;
    assign status    = status_reg;
    assign out_valid = out_valid_reg;

    `BBC_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(STACK_DEPTH))
    `BBC_ASSERT(a_clear_after_last, clk, rst_n, (take && item.last) |=> (count_reg == '0 && fail_reg == bbc_pkg::ST_OK))
    `BBC_ASSERT(a_fail_sticky, clk, rst_n, (take && !item.last && fail_reg != bbc_pkg::ST_OK) |=> ($stable(count_reg) && $stable(fail_reg)))
    `BBC_ASSERT_IMP(a_legal_match, clk, rst_n, out_valid_reg, legal_reg == (status_reg == bbc_pkg::ST_OK))

endmodule

// ----- rtl/core/bracket_balance_checker_core.sv -----
// Bracket balance checker.
// Input channel (in_valid/in_ready): one text byte per beat on char_code,
// is_last high on the final byte of a string. ( [ { < open, ) ] } > close,
// anything else is ignored.
// Output channel (out_valid/out_ready): one verdict beat per string, sent
// for the beat that carried is_last. legal is 1 when status is 0;
// status 1 = mismatch or close on empty, 2 = unclosed open, 3 = overflow.
// Throughput: one byte per cycle sustained unless a pending verdict stalls
// the input. Each bracket byte does at most one push or pop on the bracket
// stack RAM, with the top entry held in a register so that back-to-back
// pops need no RAM read in the compare path. A last byte passes the decode
// register, then the queue, then the stack update that sets out_valid.
// A 2-entry queue sits between decode and stack stages; if out_ready is
// low, bytes keep flowing until a later is_last byte reaches the stack
// stage while a verdict is still pending, and then in_ready drops once the
// queue and decode register fill.
// Reset (rst_n low, async): stack empty, no failure, no verdict pending.
// The stack RAM itself is not cleared; only entries below the count are read.
module bracket_balance_checker_core
#(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       legal,
    output logic [1:0] status,
    output logic       out_valid,
    input  logic       out_ready
);

    // decoded bytes, front to queue
    bbc_pkg::item_t f_item;
    logic           f_valid;
    logic           f_ready;

    // queue to stack stage
    bbc_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;

    bbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .is_last    (is_last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    bbc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (f_item),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    bbc_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .legal      (legal),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ----- test/bbc_verdict_check.sv -----
// Watches both channels of the bracket checker, keeps its own bracket stack
// and queues the verdict each string should produce. Verdict beats are
// compared field by field against the oldest queued verdict.
module bbc_verdict_check
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       legal,
    input  logic [1:0] status,
    input  logic       out_valid,
    input  logic       out_ready,
    output int         mismatches,
    output int         pending_verdicts
);

    typedef struct packed {
        logic       legal;
        logic [1:0] status;
    } verdict_t;

    logic [1:0] kind_stack [STACK_DEPTH];
    int         nest_depth;
    logic [1:0] first_fault;
    verdict_t   expected_verdicts [$];

    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        $display("ERROR at %0t: %s: got %b, want %b", $time, what, got, want);
        mismatches++;
    endtask

    function automatic op_t classify(input logic [7:0] c, output logic [1:0] k);
        k = KIND_ROUND;
        case (c)
            CH_OPEN_ROUND:   begin k = KIND_ROUND;  return OP_PUSH; end
            CH_OPEN_SQUARE:  begin k = KIND_SQUARE; return OP_PUSH; end
            CH_OPEN_CURLY:   begin k = KIND_CURLY;  return OP_PUSH; end
            CH_OPEN_ANGLE:   begin k = KIND_ANGLE;  return OP_PUSH; end
            CH_CLOSE_ROUND:  begin k = KIND_ROUND;  return OP_POP; end
            CH_CLOSE_SQUARE: begin k = KIND_SQUARE; return OP_POP; end
            CH_CLOSE_CURLY:  begin k = KIND_CURLY;  return OP_POP; end
            CH_CLOSE_ANGLE:  begin k = KIND_ANGLE;  return OP_POP; end
            default:         return OP_NONE;
        endcase
    endfunction

    // one accepted text byte; queues a verdict on the last byte of a string
    task automatic absorb_byte(input logic [7:0] c, input logic last);
        logic [1:0] k;
        op_t        op;
        verdict_t   v;
        op = classify(c, k);
        // first failure sticks, later bytes leave everything alone
        if (first_fault == ST_OK)
        begin
            case (op)
                OP_PUSH:
                begin
                    if (nest_depth >= STACK_DEPTH)
                        first_fault = ST_OVERFLOW;
                    else
                    begin
                        kind_stack[nest_depth] = k;
                        nest_depth++;
                    end
                end
                OP_POP:
                begin
                    if (nest_depth == 0 || kind_stack[nest_depth - 1] != k)
                        first_fault = ST_MISMATCH;
                    else
                        nest_depth--;
                end
                default:
                begin
                end
            endcase
        end
        if (last)
        begin
            if (first_fault != ST_OK)
                v.status = first_fault;
            else if (nest_depth != 0)
                v.status = ST_UNCLOSED;
            else
                v.status = ST_OK;
            v.legal = (v.status == ST_OK);
            expected_verdicts.push_back(v);
            nest_depth  = 0;
            first_fault = ST_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nest_depth  = 0;
            first_fault = ST_OK;
            mismatches  = 0;
            expected_verdicts.delete();
        end
        else
        begin
            // a verdict beat never belongs to the byte taken on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("verdict with none pending", status, 2'bxx);
                else
                begin
                    verdict_t want;
                    want = expected_verdicts.pop_front();
                    if (legal !== want.legal)
                        report_mismatch("legal", {1'b0, legal}, {1'b0, want.legal});
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
            if (in_valid && in_ready)
                absorb_byte(char_code, is_last);
        end
        pending_verdicts = expected_verdicts.size();
    end

endmodule

// ----- test/testbench.sv -----
// Top of the bracket checker regression. It makes the byte stream and the
// receiver's ready pattern; bbc_verdict_check does all prediction and
// comparison and hands back a mismatch count.
module testbench;

    import bbc_pkg::*;

    // No beat on either channel for this many cycles means a hang. Normal
    // quiet spells come from sender gaps, receiver stall runs and pipeline
    // latency.
    localparam int QUIET_LIMIT  = 1000;
    localparam int TARGET_BYTES = 1700;

    typedef enum int {
        RX_FREE,
        RX_CHOPPY,
        RX_BLOCKY
    } rx_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       is_last   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       legal;
    logic [1:0] status;
    logic       out_valid;
    logic       out_ready = 1'b0;

    int mismatches;
    int pending_verdicts;

    // bytes of the string being built, sent front to back
    logic [7:0] text [$];
    int         burst_left   = 0;
    int         bytes_sent   = 0;
    int         quiet_cycles = 0;

    // receiver pattern state
    rx_mode_t rx_mode    = RX_FREE;
    int       rx_left    = 0;
    int       stall_run  = 0;

    bracket_balance_checker_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .is_last   (is_last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .legal     (legal),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    bbc_verdict_check i_verdict_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_code        (char_code),
        .is_last          (is_last),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .legal            (legal),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mismatches       (mismatches),
        .pending_verdicts (pending_verdicts)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: switches at random between free flow, random chop and long
    // stall runs, so back-pressure lands on every pipeline phase.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        if (stall_run != 0)
        begin
            stall_run--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:
                    out_ready <= 1'b1;
                RX_CHOPPY:
                    out_ready <= ($urandom_range(0, 99) < 60);
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_run = $urandom_range(1, 30);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    // Watchdog: any beat on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bracket_balance_checker_core regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] open_char(input logic [1:0] k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    // Filler bytes come from ranges that hold no bracket character.
    function automatic logic [7:0] filler_char();
        if ($urandom_range(0, 1) != 0)
            return $urandom_range(8'h80, 8'hFF);
        return $urandom_range(8'h00, 8'h27);
    endfunction

    // One input beat. Valid goes high at a falling edge and holds with the
    // payload until the rising edge that takes it. Bursts of random length
    // alternate with random gaps; during a gap the payload is garbage.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 16);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid  <= 1'b0;
                char_code <= $urandom_range(0, 255);
                is_last   <= $urandom_range(0, 1);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sends the string held in text; is_last rides on its final byte.
    task automatic send_text();
        int i;
        for (i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
        bytes_sent += text.size();
    endtask

    // Drops valid and holds off until every queued verdict has been seen.
    task automatic wait_for_verdicts();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts != 0)
            @(negedge clk);
    endtask

    // Random well-nested string: opens, matching closes and filler, with any
    // still-open brackets closed at the end.
    task automatic build_balanced(input int max_depth, input int len_hint);
        logic [1:0] open_kinds [$];
        logic [1:0] k;
        int         steps;
        text.delete();
        steps = $urandom_range(1, len_hint);
        repeat (steps)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (open_kinds.size() < max_depth)
                    begin
                        k = $urandom_range(0, 3);
                        open_kinds.push_back(k);
                        text.push_back(open_char(k));
                    end
                end
                1:
                begin
                    if (open_kinds.size() != 0)
                        text.push_back(close_char(open_kinds.pop_back()));
                end
                default:
                    text.push_back(filler_char());
            endcase
        end
        while (open_kinds.size() != 0)
            text.push_back(close_char(open_kinds.pop_back()));
        if (text.size() == 0)
            text.push_back(filler_char());
    endtask

    initial
    begin
        int         pick;
        int         depth;
        int         strings_sent;
        logic [1:0] k;
        logic [1:0] nest_kinds [$];

        strings_sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // lone last byte that is no bracket, at both ends of the byte range
        text = '{8'h00};
        send_text();
        text = '{8'hFF};
        send_text();
        // every bracket kind, nested and closed in order
        text = '{CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE,
                 CH_CLOSE_ANGLE, CH_CLOSE_CURLY, CH_CLOSE_SQUARE, CH_CLOSE_ROUND};
        send_text();
        // close with nothing open
        text = '{CH_CLOSE_ROUND};
        send_text();
        // close of the wrong kind
        text = '{CH_OPEN_CURLY, CH_CLOSE_SQUARE};
        send_text();
        // open left unclosed at the end
        text = '{CH_OPEN_ANGLE};
        send_text();
        // early failure must stick even though the rest balances
        text = '{CH_CLOSE_ANGLE, CH_OPEN_ROUND, CH_CLOSE_ROUND};
        send_text();
        // state must have cleared after the failing string
        text = '{CH_OPEN_SQUARE, 8'h41, CH_CLOSE_SQUARE};
        send_text();
        wait_for_verdicts();

        // ---- random part ----
        while (bytes_sent < TARGET_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                build_balanced(8, 24);
            else if (pick < 65)
            begin
                // well-nested string broken in one place
                build_balanced(6, 16);
                k = $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0:
                        text[$urandom_range(0, text.size() - 1)] =
                            ($urandom_range(0, 1) != 0) ? open_char(k) : close_char(k);
                    1:
                    begin
                        void'(text.pop_back());
                        if (text.size() == 0)
                            text.push_back(filler_char());
                    end
                    default:
                        text.push_front(close_char(k));
                endcase
            end
            else if (pick < 90)
            begin
                // noise: brackets and arbitrary bytes in any order
                text.delete();
                repeat ($urandom_range(1, 16))
                begin
                    k = $urandom_range(0, 3);
                    case ($urandom_range(0, 3))
                        0:       text.push_back(open_char(k));
                        1:       text.push_back(close_char(k));
                        default: text.push_back($urandom_range(0, 255));
                    endcase
                end
            end
            else if (pick < 92)
            begin
                // deep nesting around the stack depth: below it, full, and one or two
                // pushes past it for overflow
                depth = $urandom_range(STACK_DEPTH_DEF - 4, STACK_DEPTH_DEF + 2);
                text.delete();
                nest_kinds.delete();
                repeat (depth)
                begin
                    k = $urandom_range(0, 3);
                    nest_kinds.push_back(k);
                    text.push_back(open_char(k));
                end
                while (nest_kinds.size() != 0)
                    text.push_back(close_char(nest_kinds.pop_back()));
            end
            else
                build_balanced(3, 6);
            send_text();
            strings_sent++;
            // now and then let the block drain completely
            if (strings_sent % 37 == 0)
                wait_for_verdicts();
        end

        wait_for_verdicts();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("bracket_balance_checker_core regression: pass");
        else
            $display("bracket_balance_checker_core regression: fail");
        $finish;
    end

endmodule
